### src/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// Holds status codes, byte class limits, codepoint limits and the result group type.
// No dependencies.
package utf8v_pkg;

	// Status codes carried on every result beat
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
	localparam logic [2:0] ST_BAD_CONT  = 3'd2;
	localparam logic [2:0] ST_BAD_CP    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	// Item opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Lead byte classes
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	// Sequence lengths
	localparam logic [2:0] LEN2 = 3'd2;
	localparam logic [2:0] LEN3 = 3'd3;
	localparam logic [2:0] LEN4 = 3'd4;

	// Codepoint limits
	localparam logic [20:0] CP_MIN2 = 21'h00080;
	localparam logic [20:0] CP_MIN3 = 21'h00800;
	localparam logic [20:0] CP_MIN4 = 21'h10000;
	localparam logic [20:0] SURR_LO = 21'h0D800;
	localparam logic [20:0] SURR_HI = 21'h0DFFF;
	localparam logic [20:0] CP_MAX  = 21'h10FFFF;

	// One group of result beats caused by a single item
	typedef struct packed {
		logic [2:0]      cnt;     // number of beats, 0..4
		logic [3:0][7:0] bytes;   // beat k carries bytes[k]
		logic [20:0]     cp;
		logic [2:0]      status;
	} grp_t;

endpackage

### src/utf8v_decode.sv
// Sequence tracker of the UTF-8 stream validator: holds the open sequence and
// the sticky fault, and turns one item into a group of result beats.
// Depends on utf8v_pkg.
module utf8v_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,        // item in the input register is consumed
	input  logic             op,
	input  logic [7:0]       data_byte,
	output utf8v_pkg::grp_t  grp
);

	logic [2:0][7:0] held_q, held_d;
	logic [1:0]      cnt_q, cnt_d;
	logic [2:0]      exp_q, exp_d;
	logic [20:0]     part_q, part_d;
	logic [2:0]      fault_q, fault_d;

	logic [20:0] cp_new;
	logic [20:0] cp_min;
	logic        cp_bad;
	logic        more;

	// Codepoint with this continuation byte appended
	assign cp_new = {part_q[14:0], data_byte[5:0]};
	assign cp_min = (exp_q == utf8v_pkg::LEN2) ? utf8v_pkg::CP_MIN2 :
	                (exp_q == utf8v_pkg::LEN3) ? utf8v_pkg::CP_MIN3 : utf8v_pkg::CP_MIN4;
	assign cp_bad = (cp_new < cp_min)
	             || ((cp_new >= utf8v_pkg::SURR_LO) && (cp_new <= utf8v_pkg::SURR_HI))
	             || (cp_new > utf8v_pkg::CP_MAX);
	assign more   = (({1'b0, cnt_q} + 3'd1) < exp_q);

	// Next state and result group
	always_comb begin
		held_d  = held_q;
		cnt_d   = cnt_q;
		exp_d   = exp_q;
		part_d  = part_q;
		fault_d = fault_q;
		grp     = '0;
		if (fault_q != utf8v_pkg::ST_OK) begin
			// swallow everything until reset
			grp.cnt    = 3'd1;
			grp.status = fault_q;
		end else if (op == utf8v_pkg::OP_END) begin
			if (cnt_q != 2'd0) begin
				cnt_d      = 2'd0;
				exp_d      = 3'd0;
				part_d     = '0;
				fault_d    = utf8v_pkg::ST_TRUNCATED;
				grp.cnt    = 3'd1;
				grp.status = utf8v_pkg::ST_TRUNCATED;
			end
		end else if (cnt_q == 2'd0) begin
			// lead byte
			if (data_byte <= utf8v_pkg::ASCII_MAX) begin
				grp.cnt      = 3'd1;
				grp.bytes[0] = data_byte;
				grp.cp       = {13'd0, data_byte};
			end else if (data_byte >= utf8v_pkg::LEAD2_MIN && data_byte <= utf8v_pkg::LEAD2_MAX) begin
				exp_d     = utf8v_pkg::LEN2;
				part_d    = {16'd0, data_byte[4:0]};
				held_d[0] = data_byte;
				cnt_d     = 2'd1;
			end else if (data_byte >= utf8v_pkg::LEAD3_MIN && data_byte <= utf8v_pkg::LEAD3_MAX) begin
				exp_d     = utf8v_pkg::LEN3;
				part_d    = {17'd0, data_byte[3:0]};
				held_d[0] = data_byte;
				cnt_d     = 2'd1;
			end else if (data_byte >= utf8v_pkg::LEAD4_MIN && data_byte <= utf8v_pkg::LEAD4_MAX) begin
				exp_d     = utf8v_pkg::LEN4;
				part_d    = {18'd0, data_byte[2:0]};
				held_d[0] = data_byte;
				cnt_d     = 2'd1;
			end else begin
				fault_d    = utf8v_pkg::ST_BAD_LEAD;
				grp.cnt    = 3'd1;
				grp.status = utf8v_pkg::ST_BAD_LEAD;
			end
		end else if (data_byte[7:6] != 2'b10) begin
			// not a continuation byte
			cnt_d      = 2'd0;
			exp_d      = 3'd0;
			part_d     = '0;
			fault_d    = utf8v_pkg::ST_BAD_CONT;
			grp.cnt    = 3'd1;
			grp.status = utf8v_pkg::ST_BAD_CONT;
		end else if (more) begin
			// keep collecting
			part_d = cp_new;
			if (cnt_q == 2'd1) begin
				held_d[1] = data_byte;
			end
			if (cnt_q == 2'd2) begin
				held_d[2] = data_byte;
			end
			cnt_d = cnt_q + 2'd1;
		end else begin
			// sequence complete
			cnt_d  = 2'd0;
			exp_d  = 3'd0;
			part_d = '0;
			if (cp_bad) begin
				fault_d    = utf8v_pkg::ST_BAD_CP;
				grp.cnt    = 3'd1;
				grp.status = utf8v_pkg::ST_BAD_CP;
			end else begin
				grp.cnt      = {1'b0, cnt_q} + 3'd1;
				grp.cp       = cp_new;
				grp.bytes[0] = held_q[0];
				grp.bytes[1] = (cnt_q >= 2'd2) ? held_q[1] : data_byte;
				grp.bytes[2] = (cnt_q == 2'd3) ? held_q[2] :
				               ((cnt_q == 2'd2) ? data_byte : 8'd0);
				grp.bytes[3] = (cnt_q == 2'd3) ? data_byte : 8'd0;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			exp_q   <= '0;
			part_q  <= '0;
			fault_q <= utf8v_pkg::ST_OK;
		end else if (adv) begin
			cnt_q   <= cnt_d;
			exp_q   <= exp_d;
			part_q  <= part_d;
			fault_q <= fault_d;
		end
	end

	// Held bytes, read only below the fill count
	always_ff @(posedge clk) begin
		if (adv) begin
			held_q <= held_d;
		end
	end

endmodule

### src/utf8v_burst.sv
// Result register of the UTF-8 stream validator: takes a group of up to four
// beats and presents them one per cycle on the result channel while res_stall is low.
// Depends on utf8v_pkg.
module utf8v_burst (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,       // group written this cycle
	input  utf8v_pkg::grp_t  grp,
	output logic             free,       // a group can be written this cycle
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_byte,
	output logic [20:0]      code_point,
	output logic             is_last,
	output logic [2:0]       status
);

	logic [2:0]      left_q;
	logic [3:0][7:0] bytes_q;
	logic [20:0]     cp_q;
	logic [2:0]      status_q;
	logic            take;

	assign take       = res_valid && !res_stall;
	assign free       = (left_q == 3'd0) || ((left_q == 3'd1) && !res_stall);
	assign res_valid  = (left_q != 3'd0);
	assign out_byte   = bytes_q[0];
	assign code_point = cp_q;
	assign is_last    = (left_q == 3'd1);
	assign status     = status_q;

	// Beat count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= grp.cnt;
		end else if (take) begin
			left_q <= left_q - 3'd1;
		end
	end

	// Payload: bytes shift down as beats go out
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= grp.bytes;
			cp_q     <= grp.cp;
			status_q <= grp.status;
		end else if (take) begin
			bytes_q <= {8'd0, bytes_q[3:1]};
		end
	end

endmodule

### src/utf8_stream_validator_unit.sv
// UTF-8 stream validator, top level.
// Instantiates utf8v_decode and utf8v_burst; depends on utf8v_pkg.
//
// Usage:
//   Byte channel (byte_valid/byte_stall, op, data_byte) takes one item per
//   beat: a data byte, or an end marker that checks for an open sequence.
//   Result channel (res_valid/res_stall, out_byte, code_point, is_last,
//   status) gives the beats caused by each item; is_last marks the final one.
//   Bytes of a multi-byte sequence are held until the sequence completes and
//   then released together, one beat per cycle while res_stall is low. A
//   fault produces a single beat with its status and locks the block: every
//   later item answers one beat carrying that fault until reset.
// Pipeline: an accepted item sits in the input register, is decoded there
//   combinationally and goes as a group into the result register, which
//   holds the group until all of its beats have been taken.
// Throughput: one item per cycle while byte_stall is low. The input register
//   waits only while a new group must go into a result register that still
//   has beats to send, so a four-byte sequence raises byte_stall when it
//   lands on a busy result register.
// Reset: arst_n clears the open sequence, the fault and both valid flags.
// A stalled result beat holds its payload; byte_stall then rises as soon as
//   the input register holds an item that produces beats.
module utf8_stream_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic [20:0] code_point,
	output logic        is_last,
	output logic [2:0]  status
);

	logic            valid_s1;
	logic            op_s1;
	logic [7:0]      byte_s1;
	logic            adv;
	logic            free;
	utf8v_pkg::grp_t grp;

	// Input register advances when its group has somewhere to go
	assign adv        = valid_s1 && ((grp.cnt == 3'd0) || free);
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
	end

	utf8v_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.op        (op_s1),
		.data_byte (byte_s1),
		.grp       (grp)
	);

	utf8v_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && (grp.cnt != 3'd0)),
		.grp        (grp),
		.free       (free),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.code_point (code_point),
		.is_last    (is_last),
		.status     (status)
	);

endmodule
